// File: src/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants of the nearest palette color unit.
// ----------------------------------------------------------------------------
package npc_pkg;

  // palette size default and field widths
  localparam int PALETTE_DEPTH_DEF = 1024;
  localparam int ENTRY_W           = 10;
  localparam int COLOR_W           = 8;
  localparam int KEY_W             = 3 * COLOR_W;
  localparam int SQ_W              = 2 * COLOR_W;
  localparam int DIST_W            = 18;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THRESHOLD = 1'b1;

  localparam logic [COLOR_W-1:0] ALPHA_THRESHOLD_RST = 8'd128;

  // request commands
  localparam logic CMD_WRITE_ENTRY = 1'b0;
  localparam logic CMD_CLASSIFY    = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_EMIT
  } npc_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic start;
    logic issue;
    logic emit;
  } npc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pixel;
    logic transparent;
    logic last_issue;
    logic pipe_busy;
    logic out_free;
  } npc_sts_t;

endpackage

// File: src/npc_req_if.sv
// ----------------------------------------------------------------------------
// npc_req_if
// Request channel: palette writes and pixels to classify.
// ----------------------------------------------------------------------------
interface npc_req_if
  import npc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [ENTRY_W-1:0] entry_index;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] alpha;

  modport source (
    output valid, cmd, entry_index, red, green, blue, alpha,
    input  ready
  );

  modport sink (
    input  valid, cmd, entry_index, red, green, blue, alpha,
    output ready
  );
endinterface

// File: src/npc_rsp_if.sv
// ----------------------------------------------------------------------------
// npc_rsp_if
// Result channel: nearest palette entry of a classified pixel.
// ----------------------------------------------------------------------------
interface npc_rsp_if
  import npc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               transparent;
  logic [ENTRY_W-1:0] best_entry;
  logic [COLOR_W-1:0] best_red;
  logic [COLOR_W-1:0] best_green;
  logic [COLOR_W-1:0] best_blue;
  logic [DIST_W-1:0]  match_dist;

  modport source (
    output valid, transparent, best_entry, best_red, best_green, best_blue,
           match_dist,
    input  ready
  );

  modport sink (
    input  valid, transparent, best_entry, best_red, best_green, best_blue,
           match_dist,
    output ready
  );
endinterface

// File: src/npc_ctrl.sv
// ----------------------------------------------------------------------------
// npc_ctrl
// Sequencer: accepts requests, runs the palette scan, hands off the result.
// ----------------------------------------------------------------------------
module npc_ctrl
  import npc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  npc_sts_t sts_i,
  output npc_cmd_t cmd_o
);

  npc_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = 1'b1;
        if (in_valid_i && sts_i.is_pixel) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.transparent ? ST_EMIT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/npc_datapath.sv
// ----------------------------------------------------------------------------
// npc_datapath
// Palette memory, distance pipeline, best-match tracking and result register.
// ----------------------------------------------------------------------------
module npc_datapath
  import npc_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // control
  input  npc_cmd_t              cmd_i,
  output npc_sts_t              sts_o,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // request payload
  input  logic                  in_valid_i,
  input  logic                  in_cmd_i,
  input  logic [ENTRY_W-1:0]    in_entry_index_i,
  input  logic [COLOR_W-1:0]    in_red_i,
  input  logic [COLOR_W-1:0]    in_green_i,
  input  logic [COLOR_W-1:0]    in_blue_i,
  input  logic [COLOR_W-1:0]    in_alpha_i,
  // result
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  out_transparent_o,
  output logic [ENTRY_W-1:0]    out_best_entry_o,
  output logic [COLOR_W-1:0]    out_best_red_o,
  output logic [COLOR_W-1:0]    out_best_green_o,
  output logic [COLOR_W-1:0]    out_best_blue_o,
  output logic [DIST_W-1:0]     out_match_dist_o
);

  localparam int AW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CW    = $clog2(PALETTE_DEPTH + 1);
  localparam int EXT_W = ENTRY_W + AW;

  // configuration registers
  logic [CW-1:0]      count_q;
  logic [COLOR_W-1:0] alpha_thr_q;
  logic [CW-1:0]      count_clamped;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      count_clamped = CW'(1);
    end else if (32'(cfg_wdata_i) > 32'(PALETTE_DEPTH)) begin
      count_clamped = CW'(PALETTE_DEPTH);
    end else begin
      count_clamped = CW'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CW'(1);
      alpha_thr_q <= ALPHA_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PALETTE_COUNT:   count_q     <= count_clamped;
        CFG_ALPHA_THRESHOLD: alpha_thr_q <= cfg_wdata_i[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request decode
  logic in_fire;
  logic wr_en;
  assign in_fire = in_valid_i && cmd_i.accept;
  assign wr_en   = in_fire && (in_cmd_i == CMD_WRITE_ENTRY) &&
                   (32'(in_entry_index_i) < 32'(PALETTE_DEPTH));

  // pixel latched at the start of a search
  logic [COLOR_W-1:0] pix_r_q, pix_g_q, pix_b_q;
  logic               pix_transp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pix_r_q      <= in_red_i;
      pix_g_q      <= in_green_i;
      pix_b_q      <= in_blue_i;
      pix_transp_q <= (in_alpha_i < alpha_thr_q);
    end
  end

  // scan address counter
  logic [AW-1:0] addr_q;
  logic          last_issue;
  assign last_issue = (CW'(addr_q) == count_q - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.start) begin
      addr_q <= '0;
    end else if (cmd_i.issue) begin
      addr_q <= addr_q + AW'(1);
    end
  end

  // palette memory, entry stored as {blue, green, red}
  logic [KEY_W-1:0] mem [PALETTE_DEPTH];
  logic [KEY_W-1:0] s1_key_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AW'(in_entry_index_i)] <= {in_blue_i, in_green_i, in_red_i};
    end
    if (cmd_i.issue) begin
      s1_key_q <= mem[addr_q];
    end
  end

  // pipeline valid bits
  logic s1_vld_q, s2_vld_q, s3_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // stage 2: per-channel absolute difference and square
  logic [AW-1:0]      s1_idx_q, s2_idx_q, s3_idx_q;
  logic [KEY_W-1:0]   s2_key_q, s3_key_q;
  logic [SQ_W-1:0]    s2_sq_r_q, s2_sq_g_q, s2_sq_b_q;
  logic [DIST_W-1:0]  s3_dist_q;
  logic [COLOR_W-1:0] dr, dg, db;
  logic [COLOR_W-1:0] key_r, key_g, key_b;

  assign key_r = s1_key_q[COLOR_W-1:0];
  assign key_g = s1_key_q[2*COLOR_W-1:COLOR_W];
  assign key_b = s1_key_q[KEY_W-1:2*COLOR_W];
  assign dr = (pix_r_q > key_r) ? (pix_r_q - key_r) : (key_r - pix_r_q);
  assign dg = (pix_g_q > key_g) ? (pix_g_q - key_g) : (key_g - pix_g_q);
  assign db = (pix_b_q > key_b) ? (pix_b_q - key_b) : (key_b - pix_b_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s1_idx_q <= addr_q;
    end
    s2_idx_q  <= s1_idx_q;
    s2_key_q  <= s1_key_q;
    s2_sq_r_q <= SQ_W'(dr) * SQ_W'(dr);
    s2_sq_g_q <= SQ_W'(dg) * SQ_W'(dg);
    s2_sq_b_q <= SQ_W'(db) * SQ_W'(db);
    // stage 3: distance sum
    s3_idx_q  <= s2_idx_q;
    s3_key_q  <= s2_key_q;
    s3_dist_q <= DIST_W'(s2_sq_r_q) + DIST_W'(s2_sq_g_q) + DIST_W'(s2_sq_b_q);
  end

  // best-match tracking, ties to the smaller packed color
  logic              have_q;
  logic [DIST_W-1:0] best_dist_q;
  logic [KEY_W-1:0]  best_key_q;
  logic [AW-1:0]     best_idx_q;
  logic              better;

  assign better = !have_q || (s3_dist_q < best_dist_q) ||
                  ((s3_dist_q == best_dist_q) && (s3_key_q < best_key_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (cmd_i.start) begin
      have_q <= 1'b0;
    end else if (s3_vld_q) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_vld_q && better) begin
      best_dist_q <= s3_dist_q;
      best_key_q  <= s3_key_q;
      best_idx_q  <= s3_idx_q;
    end
  end

  // result register
  logic               out_vld_q;
  logic               out_transp_q;
  logic [ENTRY_W-1:0] out_entry_q;
  logic [KEY_W-1:0]   out_key_q;
  logic [DIST_W-1:0]  out_dist_q;
  logic               out_free;
  logic               out_load;
  logic [EXT_W-1:0]   best_idx_ext;

  assign out_free     = !out_vld_q || out_ready_i;
  assign out_load     = cmd_i.emit && out_free;
  assign best_idx_ext = EXT_W'(best_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_transp_q <= pix_transp_q;
      if (pix_transp_q) begin
        out_entry_q <= '0;
        out_key_q   <= '0;
        out_dist_q  <= '0;
      end else begin
        out_entry_q <= best_idx_ext[ENTRY_W-1:0];
        out_key_q   <= best_key_q;
        out_dist_q  <= best_dist_q;
      end
    end
  end

  assign out_valid_o       = out_vld_q;
  assign out_transparent_o = out_transp_q;
  assign out_best_entry_o  = out_entry_q;
  assign out_best_red_o    = out_key_q[COLOR_W-1:0];
  assign out_best_green_o  = out_key_q[2*COLOR_W-1:COLOR_W];
  assign out_best_blue_o   = out_key_q[KEY_W-1:2*COLOR_W];
  assign out_match_dist_o  = out_dist_q;

  // status to the controller
  always_comb begin
    sts_o             = '0;
    sts_o.is_pixel    = (in_cmd_i == CMD_CLASSIFY);
    sts_o.transparent = (in_alpha_i < alpha_thr_q);
    sts_o.last_issue  = last_issue;
    sts_o.pipe_busy   = s1_vld_q || s2_vld_q || s3_vld_q;
    sts_o.out_free    = out_free;
  end

  // checks
  a_emit_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(s1_vld_q || s2_vld_q || s3_vld_q))
    else $error("result handed off while the distance pipeline is busy");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (CW'(addr_q) < count_q))
    else $error("scan address beyond the searched entry count");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (32'(count_q) <= 32'(PALETTE_DEPTH)))
    else $error("searched entry count out of range");

  a_opaque_has_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !pix_transp_q) |-> have_q)
    else $error("opaque result loaded without any scanned entry");

  a_transparent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_transp_q) |-> ((out_dist_q == '0) && (out_entry_q == '0)
                                     && (out_key_q == '0)))
    else $error("transparent result carries nonzero fields");

endmodule

// File: src/nearest_palette_color_unit.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_unit
// Nearest-color quantizer over a writable RGB palette.
// ----------------------------------------------------------------------------
// A write request (cmd 0) stores one palette entry; indexes at or above
// PALETTE_DEPTH are dropped. A classify request (cmd 1) whose alpha is below
// alpha_threshold returns a transparent result without a palette scan. Any
// other pixel scans entries 0 to palette_count-1 (zero counts as one, larger
// values stop at PALETTE_DEPTH) and returns the entry with the least squared
// RGB distance, ties going to the smaller blue:green:red value and then the
// lower index; the palette memory read port delivers one entry per cycle into
// the distance pipeline. New requests are taken only between scans, while an
// earlier result may still wait in the output register. Entries must be
// written before they are searched. The user must see that registers are
// written only while the unit is idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module nearest_palette_color_unit
  import npc_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  npc_req_if.sink               in_ch,
  npc_rsp_if.source             out_ch
);

  npc_cmd_t ctrl_cmd;
  npc_sts_t dp_sts;

  // request handshake
  assign in_ch.ready = ctrl_cmd.accept;

  // sequencer
  npc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  // datapath
  npc_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (ctrl_cmd),
    .sts_o             (dp_sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_ch.valid),
    .in_cmd_i          (in_ch.cmd),
    .in_entry_index_i  (in_ch.entry_index),
    .in_red_i          (in_ch.red),
    .in_green_i        (in_ch.green),
    .in_blue_i         (in_ch.blue),
    .in_alpha_i        (in_ch.alpha),
    .out_ready_i       (out_ch.ready),
    .out_valid_o       (out_ch.valid),
    .out_transparent_o (out_ch.transparent),
    .out_best_entry_o  (out_ch.best_entry),
    .out_best_red_o    (out_ch.best_red),
    .out_best_green_o  (out_ch.best_green),
    .out_best_blue_o   (out_ch.best_blue),
    .out_match_dist_o  (out_ch.match_dist)
  );

endmodule
